@@ rtl/core/vds_pkg.sv @@
`timescale 1ns / 1ps
package vds_pkg;

   localparam int ACC_W     = 48;
   localparam int PROD_W    = 96;
   localparam int ROOT_W    = 48;
   localparam int SREM_W    = 50;
   localparam int DREM_W    = 49;
   localparam int FRAC_W    = 30;
   localparam int STEP_W    = 7;

   localparam logic [STEP_W-1:0] MUL_LAST  = 7'd47;
   localparam logic [STEP_W-1:0] SQRT_LAST = 7'd47;
   localparam logic [STEP_W-1:0] DIV_INT   = 7'd48;
   localparam logic [STEP_W-1:0] DIV_LAST  = 7'd77;

   typedef enum logic [1:0] {
      MODE_EUCLID    = 2'd0,
      MODE_MANHATTAN = 2'd1,
      MODE_COSINE    = 2'd2,
      MODE_NONE      = 2'd3
   } mode_type;

   typedef struct packed {
      logic acc_en;
      logic clear;
      logic mul_load;
      logic mul_step;
      logic sqrt_load;
      logic sqrt_step;
      logic div_load;
      logic div_step;
      logic div_frac;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic vec_end;
      logic norm_bad;
   } status_type;

   // saturating add of a signed term onto a signed accumulator
   function automatic logic [ACC_W:0] sat_add(input logic [ACC_W-1:0] sum,
                                              input logic [ACC_W-1:0] term);
      logic signed [ACC_W:0] s;
      logic                  clip;
      logic [ACC_W-1:0]      r;
      s    = $signed({sum[ACC_W-1], sum}) + $signed({term[ACC_W-1], term});
      clip = s[ACC_W] != s[ACC_W-1];
      if (!clip) r = s[ACC_W-1:0];
      else if (s[ACC_W]) r = {1'b1, {(ACC_W-1){1'b0}}};
      else r = {1'b0, {(ACC_W-1){1'b1}}};
      return {clip, r};
   endfunction

endpackage

@@ rtl/core/vector_distance_similarity.sv @@
`timescale 1ns / 1ps
// Vector distance / similarity engine.
// req channel: one element pair per transfer, x and y signed Q8.8, tlast on
//   the final pair (a vector also ends at its MAX_LEN-th pair).
// rsp channel: one result per vector: distance (Q8.8) or cosine (Q1.30),
//   with invalid and saturated flags in tuser.
// csr channel: writes the 2-bit mode; write only while the block is idle.
// Throughput: one pair per cycle while a vector streams in.
// Path from the last pair's transfer to rsp_tvalid: manhattan, unused mode
//   and cosine with a zero norm go S_START, S_OUT; euclidean adds S_SQLD and
//   a 48-step root; cosine runs a 48-step norm product, a 48-step root and a
//   78-step divide, one bit per cycle each, before S_OUT loads the result.
// No pairs are taken while the result is computed; pairs of the next vector
//   are taken while a finished result waits in the output register.
// If rsp_tready is held low, the next vector's end stalls req until the
//   pending result is taken.
// Reset clears mode to euclidean, all sums and the output register valid.
module vector_distance_similarity
   import vds_pkg::*;
#(
   parameter int MAX_LEN    = 1024,
   parameter int ELEM_WIDTH = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_elem[15:0], y_elem[31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result[31:0]
   output logic [1:0]  rsp_tuser,   // invalid[0], saturated[1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_wdata    // mode[1:0]
);

   mode_type   mode_ff, mode_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;
   assign mode_in   = csr_valid ? mode_type'(csr_wdata) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_EUCLID;
      else mode_ff <= mode_in;
   end

   vds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vds_datapath #(
      .MAX_LEN    (MAX_LEN),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .x_elem    (req_tdata[15:0]),
      .y_elem    (req_tdata[31:16]),
      .last      (req_tlast),
      .cmd       (cmd),
      .status    (status),
      .result    (rsp_tdata),
      .invalid   (rsp_tuser[0]),
      .saturated (rsp_tuser[1])
   );

endmodule

@@ rtl/core/vds_ctrl.sv @@
`timescale 1ns / 1ps
module vds_ctrl
   import vds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mode_type   mode,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_ACC   = 8'b0000_0001,
      S_START = 8'b0000_0010,
      S_MUL   = 8'b0000_0100,
      S_SQLD  = 8'b0000_1000,
      S_SQRT  = 8'b0001_0000,
      S_DVLD  = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic              slot_free;
   logic              last_step;

   assign req_tready = state_ff == S_ACC;
   assign rsp_tvalid = valid_ff;
   assign slot_free  = !valid_ff || rsp_tready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      last_step = 1'b0;
      unique case (state_ff)
         S_ACC: begin
            cmd.acc_en = req_tvalid;
            if (req_tvalid && status.vec_end) state_in = S_START;
         end
         S_START: begin
            if (mode == MODE_EUCLID) begin
               state_in = S_SQLD;
            end else if (mode == MODE_COSINE && !status.norm_bad) begin
               cmd.mul_load = 1'b1;
               state_in     = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            last_step    = cnt_ff == MUL_LAST;
            if (last_step) state_in = S_SQLD;
         end
         S_SQLD: begin
            cmd.sqrt_load = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            last_step     = cnt_ff == SQRT_LAST;
            if (last_step) state_in = (mode == MODE_COSINE) ? S_DVLD : S_OUT;
         end
         S_DVLD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_frac = cnt_ff >= DIV_INT;
            last_step    = cnt_ff == DIV_LAST;
            if (last_step) state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_comb begin
      if ((cmd.mul_step || cmd.sqrt_step || cmd.div_step) && !last_step)
         cnt_in = cnt_ff + 1'b1;
      else
         cnt_in = '0;
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTHESIS
   a_end_starts: assert property (@(posedge clock) disable iff (reset)
      (cmd.acc_en && status.vec_end) |=> state_ff == S_START)
      else $error("vector end did not start result computation");
   a_div_cosine: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> mode == MODE_COSINE)
      else $error("divider running outside cosine mode");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DIV_LAST)
      else $error("step counter out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.out_load)
      else $error("pending result overwritten");
`endif

endmodule

@@ rtl/core/vds_datapath.sv @@
`timescale 1ns / 1ps
module vds_datapath
   import vds_pkg::*;
#(
   parameter int MAX_LEN    = 1024,
   parameter int ELEM_WIDTH = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  mode_type    mode,
   input  logic [15:0] x_elem,
   input  logic [15:0] y_elem,
   input  logic        last,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] result,
   output logic        invalid,
   output logic        saturated
);

   localparam int EW    = (ELEM_WIDTH < 16) ? ELEM_WIDTH : 16;
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [ACC_W-1:0]  main_ff, main_in, nx_ff, nx_in, ny_ff, ny_in;
   logic              sat_ff, sat_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic signed [16:0] xs, ys;
   logic signed [17:0] d;
   logic signed [35:0] dd;
   logic signed [33:0] xy, xx, yy;
   logic [17:0]        ad;
   logic [ACC_W-1:0]   term;
   logic [ACC_W:0]     s_main, s_nx, s_ny;

   assign xs = {{(17 - EW){x_elem[EW-1]}}, x_elem[EW-1:0]};
   assign ys = {{(17 - EW){y_elem[EW-1]}}, y_elem[EW-1:0]};
   assign d  = 18'(xs) - 18'(ys);
   assign dd = d * d;
   assign xy = xs * ys;
   assign xx = xs * xs;
   assign yy = ys * ys;
   assign ad = d[17] ? 18'(-d) : 18'(d);

   always_comb begin
      unique case (mode)
         MODE_EUCLID:    term = ACC_W'(dd);
         MODE_MANHATTAN: term = ACC_W'(ad);
         MODE_COSINE:    term = ACC_W'(xy);
         default:        term = '0;
      endcase
   end

   assign s_main = sat_add(main_ff, term);
   assign s_nx   = sat_add(nx_ff, {{(ACC_W - 34){xx[33]}}, xx});
   assign s_ny   = sat_add(ny_ff, {{(ACC_W - 34){yy[33]}}, yy});

   assign status.vec_end  = last || (cnt_ff == CNT_W'(MAX_LEN - 1));
   assign status.norm_bad = nx_ff[ACC_W-1] || (nx_ff == '0)
                            || ny_ff[ACC_W-1] || (ny_ff == '0);

   always_comb begin
      main_in = main_ff;
      nx_in   = nx_ff;
      ny_in   = ny_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      if (cmd.clear) begin
         main_in = '0;
         nx_in   = '0;
         ny_in   = '0;
         sat_in  = 1'b0;
         cnt_in  = '0;
      end else if (cmd.acc_en) begin
         cnt_in = cnt_ff + 1'b1;
         if (mode != MODE_NONE) begin
            main_in = s_main[ACC_W-1:0];
            sat_in  = sat_ff | s_main[ACC_W];
         end
         if (mode == MODE_COSINE) begin
            nx_in  = s_nx[ACC_W-1:0];
            ny_in  = s_ny[ACC_W-1:0];
            sat_in = sat_ff | s_main[ACC_W] | s_nx[ACC_W] | s_ny[ACC_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
         nx_ff   <= '0;
         ny_ff   <= '0;
         sat_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         main_ff <= main_in;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         sat_ff  <= sat_in;
         cnt_ff  <= cnt_in;
      end
   end

   // shift-add multiplier for the norm product
   logic [PROD_W-1:0] pacc_ff, pacc_in, pa_ff, pa_in;
   logic [ACC_W-1:0]  pb_ff, pb_in;

   always_comb begin
      pacc_in = pacc_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      if (cmd.mul_load) begin
         pacc_in = '0;
         pa_in   = PROD_W'(nx_ff);
         pb_in   = ny_ff;
      end else if (cmd.mul_step) begin
         if (pb_ff[0]) pacc_in = pacc_ff + pa_ff;
         pa_in = {pa_ff[PROD_W-2:0], 1'b0};
         pb_in = {1'b0, pb_ff[ACC_W-1:1]};
      end
   end

   // restoring square root, two radicand bits per step
   logic [PROD_W-1:0] rad_ff, rad_in;
   logic [SREM_W-1:0] srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SREM_W+1:0] st, strial;

   assign st     = {srem_ff, rad_ff[PROD_W-1 -: 2]};
   assign strial = (SREM_W + 2)'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.sqrt_load) begin
         rad_in  = (mode == MODE_COSINE) ? pacc_ff
                 : PROD_W'({{(64 - ACC_W){main_ff[ACC_W-1]}}, main_ff});
         srem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in = {rad_ff[PROD_W-3:0], 2'b00};
         if (st >= strial) begin
            srem_in = SREM_W'(st - strial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_in = SREM_W'(st);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // restoring divider: integer quotient bits, then fraction bits
   logic [ACC_W-1:0]  dvd_ff, dvd_in, qi_ff, qi_in, mag;
   logic [FRAC_W-1:0] qf_ff, qf_in;
   logic [DREM_W-1:0] drem_ff, drem_in, dt, dden;
   logic              qbit, neg;

   assign neg  = main_ff[ACC_W-1];
   assign mag  = neg ? ACC_W'(-main_ff) : main_ff;
   assign dt   = {drem_ff[DREM_W-2:0], cmd.div_frac ? 1'b0 : dvd_ff[ACC_W-1]};
   assign dden = DREM_W'(root_ff);
   assign qbit = dt >= dden;

   always_comb begin
      dvd_in  = dvd_ff;
      qi_in   = qi_ff;
      qf_in   = qf_ff;
      drem_in = drem_ff;
      if (cmd.div_load) begin
         dvd_in  = mag;
         qi_in   = '0;
         qf_in   = '0;
         drem_in = '0;
      end else if (cmd.div_step) begin
         dvd_in  = {dvd_ff[ACC_W-2:0], 1'b0};
         drem_in = qbit ? dt - dden : dt;
         if (cmd.div_frac) qf_in = {qf_ff[FRAC_W-2:0], qbit};
         else qi_in = {qi_ff[ACC_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      pacc_ff <= pacc_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      dvd_ff  <= dvd_in;
      qi_ff   <= qi_in;
      qf_ff   <= qf_in;
      drem_ff <= drem_in;
   end

   // result formatting
   logic [1:0]  qint;
   logic [31:0] q32, qc, res_c;
   logic        inv_c, sat_c;

   assign qint = (qi_ff > ACC_W'(2)) ? 2'd2 : qi_ff[1:0];
   assign q32  = {qint, qf_ff};
   assign qc   = (q32 > 32'h4000_0000) ? 32'h4000_0000 : q32;

   always_comb begin
      res_c = '0;
      inv_c = 1'b0;
      sat_c = sat_ff;
      unique case (mode)
         MODE_EUCLID: res_c = root_ff[31:0];
         MODE_MANHATTAN: begin
            if ($signed(main_ff) > $signed(ACC_W'(32'h7FFF_FFFF))) begin
               res_c = 32'h7FFF_FFFF;
               sat_c = 1'b1;
            end else begin
               res_c = main_ff[31:0];
            end
         end
         MODE_COSINE: begin
            if (status.norm_bad) begin
               inv_c = 1'b1;
            end else begin
               res_c = neg ? 32'(-qc) : qc;
               sat_c = sat_ff | (q32 > 32'h4000_0000);
            end
         end
         default: begin
            inv_c = 1'b1;
            sat_c = 1'b0;
         end
      endcase
   end

   logic [31:0] res_ff;
   logic        inv_ff, osat_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_ff  <= res_c;
         inv_ff  <= inv_c;
         osat_ff <= sat_c;
      end
   end

   assign result    = res_ff;
   assign invalid   = inv_ff;
   assign saturated = osat_ff;

endmodule
